@@ src/sld_pkg.sv @@
`default_nettype none

package sld_pkg;

  // Value format: signed Q8.16 in 24 bits
  localparam int unsigned VAL_W = 24;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;

  // Rate register and step count share the divisor width
  localparam int unsigned DEN_W = 16;
  localparam logic [DEN_W-1:0] RATE_RESET = 16'd60;

  // Command codes
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_SET_AMP  = 2'd1;
  localparam logic [1:0] CMD_SET_FREQ = 2'd2;
  localparam logic [1:0] CMD_INIT     = 2'd3;

  // Shared multiplier: 32x32 unsigned, 4 bits of the multiplier per cycle
  localparam int unsigned MUL_W   = 32;
  localparam int unsigned MUL_DIG = 4;

  // Quarter-wave polynomial, Q30 coefficients
  localparam int unsigned Q_FRAC = 30;
  localparam int unsigned X_W    = 31;
  localparam logic [MUL_W-1:0] SIN_C1 = 32'd1686629713;
  localparam logic [MUL_W-1:0] SIN_C3 = 32'd693598669;
  localparam logic [MUL_W-1:0] SIN_C5 = 32'd85569305;
  localparam logic [MUL_W-1:0] SIN_C7 = 32'd5026997;
  localparam logic [MUL_W-1:0] SIN_C9 = 32'd172271;
  localparam logic [16:0]      SIN_ONE = 17'd65536;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [VAL_W-1:0] target_amplitude;
    logic [DEN_W-1:0]        step_count;
    logic signed [VAL_W-1:0] frequency;
    logic signed [VAL_W-1:0] init_value;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] lfo_value;
    logic signed [VAL_W-1:0] amplitude;
  } res_t;

endpackage

`default_nettype wire

@@ src/sld_stream_if.sv @@
`default_nettype none

// Valid/ready channel; a transfer happens when both are high at a clock edge
interface sld_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/sld_mul.sv @@
`default_nettype none

// Unsigned multiplier, one 4-bit digit of b per cycle, LSB first
module sld_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sld_pkg::MUL_W-1:0]    a_i,
  input  logic [sld_pkg::MUL_W-1:0]    b_i,
  output logic                         done_o,
  output logic [2*sld_pkg::MUL_W-1:0]  prod_o
);

  localparam int unsigned W     = sld_pkg::MUL_W;
  localparam int unsigned DIG   = sld_pkg::MUL_DIG;
  localparam int unsigned STEPS = W / DIG;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]     a_q;
  logic [2*W-1:0]   prod_q;
  logic [W+DIG-1:0] part;
  logic [W+DIG-1:0] sum;

  // High half accumulates; multiplier digits shift out of the low half
  assign part = (W+DIG)'(a_q) * (W+DIG)'(prod_q[DIG-1:0]);
  assign sum  = (W+DIG)'(prod_q[2*W-1:W]) + part;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      prod_q <= {{W{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_q <= {sum, prod_q[W-1:DIG]};
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

@@ src/sld_div.sv @@
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle, MSB first
module sld_div #(
  parameter int unsigned DVD_W = 39
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [DVD_W-1:0]               dividend_i,
  input  logic [sld_pkg::DEN_W-1:0]      divisor_i,
  output logic                           done_o,
  output logic [DVD_W-1:0]               quotient_o
);

  localparam int unsigned DW    = sld_pkg::DEN_W;
  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    den_q;
  logic [DW:0]      rem_sh;
  logic [DW+1:0]    trial;
  logic             fits;
  logic [DW-1:0]    rem_nx;

  // Bring down the next dividend bit and try one subtraction
  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
  assign fits   = !trial[DW+1];
  assign rem_nx = fits ? trial[DW-1:0] : rem_sh[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], fits};
      rem_q <= rem_nx;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ src/sine_lfo_with_ramped_depth.sv @@
`default_nettype none

// Sine LFO with linearly ramped depth, signed Q8.16 values.
// cmd_if (sink) takes commands: tick, set amplitude target, set frequency,
// init. Every command gives exactly one result on res_if (source): the
// oscillator output and the current amplitude after the command.
// cfg_we_i/cfg_data_i write the update rate (ticks per second); write it
// only while no command is in flight. A rate of zero acts as one.
// Work from command transfer to result valid:
//   tick while running: seven passes through the shared
//     4-bit-per-cycle multiplier (sine polynomial, then depth scaling)
//   set frequency above zero: one quotient bit per cycle
//     in the serial divider (DVD_W = PHASE_BITS + 7, at least 25)
//   set target with nonzero count: the same divider
//   other commands: no arithmetic unit, straight to the output register
// One command is worked on at a time; cmd_if.ready is high only when idle.
// The result sits in an output register, so a new command is taken while
// the previous result waits; a stalled receiver holds the result and stops
// the block from finishing the next one. Reset clears the control and
// oscillator state, sets the rate to 60 and leaves the oscillator stopped.
module sine_lfo_with_ramped_depth #(
  parameter int unsigned SINE_ENTRIES = 1024,
  parameter int unsigned PHASE_BITS   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sld_pkg::DEN_W-1:0]     cfg_data_i,
  sld_stream_if.sink                    cmd_if,
  sld_stream_if.source                  res_if
);

  localparam int unsigned VW       = sld_pkg::VAL_W;
  localparam int unsigned MW       = sld_pkg::MUL_W;
  localparam int unsigned QF       = sld_pkg::Q_FRAC;
  localparam int unsigned SINE_AW  = $clog2(SINE_ENTRIES);
  localparam int unsigned SINE_K_W = SINE_AW + 1;
  localparam int unsigned X_SHIFT  = QF - SINE_AW;
  localparam int unsigned DVD_W    = (PHASE_BITS + 7 > 25) ? PHASE_BITS + 7 : 25;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] cmd_q, cmd_d;
  logic [2:0] stp_q, stp_d;
  logic       run_q, run_d;
  logic       res_valid_q, res_valid_d;
  logic [sld_pkg::DEN_W-1:0] rate_q;

  sld_pkg::res_t            res_data_q, res_data_d;
  logic signed [VW-1:0]     out_val_q, out_val_d;
  logic signed [VW-1:0]     amp_cur_q, amp_cur_d;
  logic signed [VW-1:0]     amp_tgt_q, amp_tgt_d;
  logic signed [VW-1:0]     amp_step_q, amp_step_d;
  logic [PHASE_BITS-1:0]    phase_q, phase_d;
  logic [PHASE_BITS-1:0]    inc_q, inc_d;
  logic [sld_pkg::X_W-1:0]  x_q, x_d;
  logic [sld_pkg::X_W-1:0]  x2_q, x2_d;
  logic                     s_neg_q, s_neg_d;
  logic                     quo_neg_q, quo_neg_d;

  // Shared units
  logic                     mul_start, mul_done;
  logic [MW-1:0]            mul_a, mul_b;
  logic [2*MW-1:0]          mul_prod;
  logic                     div_start, div_done;
  logic [DVD_W-1:0]         div_dvd, div_quo;
  logic [sld_pkg::DEN_W-1:0] div_den;

  sld_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  sld_div #(.DVD_W(DVD_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Ramp move toward the target, clamped at it
  logic signed [VW:0]   ramp_sum;
  logic signed [VW:0]   tgt_ext;
  logic signed [VW-1:0] ramp_next;

  assign ramp_sum = {amp_cur_q[VW-1], amp_cur_q} + {amp_step_q[VW-1], amp_step_q};
  assign tgt_ext  = {amp_tgt_q[VW-1], amp_tgt_q};

  always_comb begin
    if (!amp_step_q[VW-1] && (amp_step_q != '0) && (amp_tgt_q > amp_cur_q)) begin
      ramp_next = (ramp_sum > tgt_ext) ? amp_tgt_q : ramp_sum[VW-1:0];
    end else if (amp_step_q[VW-1] && (amp_tgt_q < amp_cur_q)) begin
      ramp_next = (ramp_sum < tgt_ext) ? amp_tgt_q : ramp_sum[VW-1:0];
    end else begin
      ramp_next = amp_cur_q;
    end
  end

  // Quarter-wave argument from the phase: quadrant and index
  logic [1:0]               quad;
  logic [SINE_AW-1:0]       ridx;
  logic [SINE_K_W-1:0]      kidx;
  logic [sld_pkg::X_W-1:0]  x_new;

  assign quad  = phase_q[PHASE_BITS-1 -: 2];
  assign ridx  = phase_q[PHASE_BITS-3 -: SINE_AW];
  assign kidx  = quad[0] ? (SINE_K_W'(SINE_ENTRIES) - {1'b0, ridx}) : {1'b0, ridx};
  assign x_new = sld_pkg::X_W'(kidx) << X_SHIFT;

  // Target difference and its saturated form
  logic signed [VW:0]   diff;
  logic [VW:0]          diff_mag;
  logic signed [VW-1:0] diff_sat;

  assign diff     = {cmd_if.data.target_amplitude[VW-1], cmd_if.data.target_amplitude}
                  - {amp_cur_q[VW-1], amp_cur_q};
  assign diff_mag = diff[VW] ? (VW+1)'(-diff) : (VW+1)'(diff);
  assign diff_sat = (diff[VW] != diff[VW-1]) ? (diff[VW] ? sld_pkg::VAL_MIN : sld_pkg::VAL_MAX)
                                              : diff[VW-1:0];

  // Signed step from the divider magnitude, saturated
  logic [VW:0]          qmag;
  logic signed [VW-1:0] step_sat;

  assign qmag = div_quo[VW:0];
  always_comb begin
    if (quo_neg_q) begin
      step_sat = (qmag > (VW+1)'(25'd8388608)) ? sld_pkg::VAL_MIN : VW'(-qmag[VW-1:0]);
    end else begin
      step_sat = (qmag > (VW+1)'(25'd8388607)) ? sld_pkg::VAL_MAX : qmag[VW-1:0];
    end
  end

  // Horner step: coefficient minus the last Q30 product
  logic [MW-1:0] poly_c;
  logic [MW-1:0] poly_p;

  always_comb begin
    case (stp_q)
      3'd1:    poly_c = sld_pkg::SIN_C7;
      3'd2:    poly_c = sld_pkg::SIN_C5;
      3'd3:    poly_c = sld_pkg::SIN_C3;
      default: poly_c = sld_pkg::SIN_C1;
    endcase
  end
  assign poly_p = poly_c - mul_prod[QF+MW-1:QF];

  // Q30 sine to Q16 with rounding and cap at one
  logic [MW:0]   s_rnd;
  logic [18:0]   s_raw;
  logic [16:0]   s_q16;

  assign s_rnd = {1'b0, mul_prod[QF+MW-1:QF]} + (MW+1)'(8192);
  assign s_raw = s_rnd[32:14];
  assign s_q16 = (s_raw > 19'(sld_pkg::SIN_ONE)) ? sld_pkg::SIN_ONE : s_raw[16:0];

  // Depth scaling: magnitudes, then sign and saturation
  logic [VW-1:0]        amp_mag;
  logic [VW-1:0]        out_mag;
  logic                 out_neg;
  logic signed [VW-1:0] out_new;

  assign amp_mag = amp_cur_q[VW-1] ? VW'(-amp_cur_q) : amp_cur_q;
  assign out_mag = mul_prod[VW+15:16];
  assign out_neg = s_neg_q ^ amp_cur_q[VW-1];
  assign out_new = out_neg ? VW'(-out_mag)
                           : (out_mag[VW-1] ? sld_pkg::VAL_MAX : out_mag);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    stp_d       = stp_q;
    run_d       = run_q;
    out_val_d   = out_val_q;
    phase_d     = phase_q;
    inc_d       = inc_q;
    amp_cur_d   = amp_cur_q;
    amp_tgt_d   = amp_tgt_q;
    amp_step_d  = amp_step_q;
    x_d         = x_q;
    x2_d        = x2_q;
    s_neg_d     = s_neg_q;
    quo_neg_d   = quo_neg_q;
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    div_dvd     = '0;
    div_den     = '0;
    res_valid_d = res_valid_q && !res_if.ready;
    res_data_d  = res_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_if.valid) begin
          cmd_d = cmd_if.data.cmd;
          unique case (cmd_if.data.cmd)
            sld_pkg::CMD_TICK: begin
              if (run_q) begin
                amp_cur_d = ramp_next;
                x_d       = x_new;
                s_neg_d   = quad[1];
                stp_d     = '0;
                mul_start = 1'b1;
                mul_a     = MW'(x_new);
                mul_b     = MW'(x_new);
                state_d   = ST_MUL;
              end else begin
                state_d = ST_OUT;
              end
            end
            sld_pkg::CMD_SET_AMP: begin
              amp_tgt_d = cmd_if.data.target_amplitude;
              if (cmd_if.data.step_count == '0) begin
                amp_cur_d  = cmd_if.data.target_amplitude;
                amp_step_d = diff_sat;
                state_d    = ST_OUT;
              end else begin
                quo_neg_d = diff[VW];
                div_start = 1'b1;
                div_dvd   = DVD_W'(diff_mag);
                div_den   = cmd_if.data.step_count;
                state_d   = ST_DIV;
              end
            end
            sld_pkg::CMD_SET_FREQ: begin
              phase_d   = '0;
              out_val_d = '0;
              run_d     = (cmd_if.data.frequency > 0);
              if (cmd_if.data.frequency > 0) begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(cmd_if.data.frequency[VW-2:0]) << (PHASE_BITS - 16);
                div_den   = (rate_q == '0) ? sld_pkg::DEN_W'(1) : rate_q;
                state_d   = ST_DIV;
              end else begin
                inc_d   = '0;
                state_d = ST_OUT;
              end
            end
            default: begin
              out_val_d = cmd_if.data.init_value;
              amp_cur_d = '0;
              amp_tgt_d = '0;
              state_d   = ST_OUT;
            end
          endcase
        end
      end

      ST_DIV: begin
        if (div_done) begin
          if (cmd_q == sld_pkg::CMD_SET_AMP) begin
            amp_step_d = step_sat;
          end else begin
            inc_d = div_quo[PHASE_BITS-1:0];
          end
          state_d = ST_OUT;
        end
      end

      ST_MUL: begin
        if (mul_done) begin
          stp_d = stp_q + 1'b1;
          unique case (stp_q) inside
            3'd0: begin
              x2_d      = mul_prod[QF+sld_pkg::X_W-1:QF];
              mul_start = 1'b1;
              mul_a     = MW'(mul_prod[QF+sld_pkg::X_W-1:QF]);
              mul_b     = sld_pkg::SIN_C9;
            end
            [3'd1:3'd3]: begin
              mul_start = 1'b1;
              mul_a     = MW'(x2_q);
              mul_b     = poly_p;
            end
            3'd4: begin
              mul_start = 1'b1;
              mul_a     = MW'(x_q);
              mul_b     = poly_p;
            end
            3'd5: begin
              mul_start = 1'b1;
              mul_a     = MW'(s_q16);
              mul_b     = MW'(amp_mag);
            end
            default: begin
              out_val_d = out_new;
              phase_d   = phase_q + inc_q;
              state_d   = ST_OUT;
            end
          endcase
        end
      end

      default: begin
        if (!res_valid_q || res_if.ready) begin
          res_valid_d          = 1'b1;
          res_data_d.lfo_value = out_val_q;
          res_data_d.amplitude = amp_cur_q;
          state_d              = ST_IDLE;
        end
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= sld_pkg::CMD_TICK;
      stp_q       <= '0;
      run_q       <= 1'b0;
      res_valid_q <= 1'b0;
      rate_q      <= sld_pkg::RATE_RESET;
      out_val_q   <= '0;
      phase_q     <= '0;
      inc_q       <= '0;
      amp_cur_q   <= '0;
      amp_tgt_q   <= '0;
      amp_step_q  <= '0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      stp_q       <= stp_d;
      run_q       <= run_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        rate_q <= cfg_data_i;
      end
      out_val_q   <= out_val_d;
      phase_q     <= phase_d;
      inc_q       <= inc_d;
      amp_cur_q   <= amp_cur_d;
      amp_tgt_q   <= amp_tgt_d;
      amp_step_q  <= amp_step_d;
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    x2_q       <= x2_d;
    s_neg_q    <= s_neg_d;
    quo_neg_q  <= quo_neg_d;
    res_data_q <= res_data_d;
  end

  assign cmd_if.ready = (state_q == ST_IDLE);
  assign res_if.valid = res_valid_q;
  assign res_if.data  = res_data_q;

endmodule

`default_nettype wire

@@ src/sld_checker.sv @@
`default_nettype none

// Port-level checks for the LFO block
module sld_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input sld_pkg::res_t out_data_i
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result payload changed while stalled");

  // One command at a time: busy right after a command transfer
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command taken while another is in flight");

  // A new result only comes out of a busy cycle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without a command in flight");

endmodule

bind sine_lfo_with_ramped_depth sld_checker u_sld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cmd_if.valid),
  .in_ready_i  (cmd_if.ready),
  .out_valid_i (res_if.valid),
  .out_ready_i (res_if.ready),
  .out_data_i  (res_if.data)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned SINE_N     = 1024;  // quarter-wave points, matches dut default
  localparam int          PHASE_SETS = 6;
  localparam int          PER_SET    = 290;   // active items per rate setting
  localparam int          HOLD_AT    = 600;   // transfers before the long sink stall
  localparam int          HOLD_LEN   = 400;
  localparam int          STUCK_MAX  = 3000;  // cycles without any transfer
  localparam int          TAIL_WAIT  = 150;

  typedef struct {
    sld_pkg::cmd_t item;
    logic          chk;
    sld_pkg::res_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [sld_pkg::DEN_W-1:0] cfg_data_i;

  sld_stream_if #(.data_t(sld_pkg::cmd_t)) cmd_if ();
  sld_stream_if #(.data_t(sld_pkg::res_t)) res_if ();

  sine_lfo_with_ramped_depth dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_if     (cmd_if),
    .res_if     (res_if)
  );

  // Oscillator state as the block should hold it
  logic [sld_pkg::DEN_W-1:0]        rate_q;
  logic signed [sld_pkg::VAL_W-1:0] out_q;
  logic signed [sld_pkg::VAL_W-1:0] amp_cur;
  logic signed [sld_pkg::VAL_W-1:0] amp_tgt;
  logic signed [sld_pkg::VAL_W-1:0] amp_step;
  logic [31:0]                      phase_acc;
  logic [31:0]                      phase_inc;
  logic                             running;

  sld_pkg::res_t pending_res_q[$];
  dir_row_t      dir_q[$];
  int            errors;
  int            results_seen;
  int            cmd_xfers;
  int            run_ticks;
  int            stuck_cycles;
  logic          idle_en;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [sld_pkg::VAL_W-1:0] sat_val(input longint v);
    if (v > 64'sd8388607) return sld_pkg::VAL_MAX;
    if (v < -64'sd8388608) return sld_pkg::VAL_MIN;
    return v[sld_pkg::VAL_W-1:0];
  endfunction

  // Q30 polynomial for one quarter-wave point, rounded to Q16 and capped at one
  function automatic longint unsigned quarter_wave(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned r;
    x  = (longint'(k) << sld_pkg::Q_FRAC) / SINE_N;
    x2 = (x * x) >> sld_pkg::Q_FRAC;
    p  = sld_pkg::SIN_C9;
    p  = sld_pkg::SIN_C7 - ((x2 * p) >> sld_pkg::Q_FRAC);
    p  = sld_pkg::SIN_C5 - ((x2 * p) >> sld_pkg::Q_FRAC);
    p  = sld_pkg::SIN_C3 - ((x2 * p) >> sld_pkg::Q_FRAC);
    p  = sld_pkg::SIN_C1 - ((x2 * p) >> sld_pkg::Q_FRAC);
    r  = (x * p) >> sld_pkg::Q_FRAC;
    r  = (r + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r;
  endfunction

  function automatic int sine_q16(input logic [31:0] ph);
    logic [11:0] idx;
    int unsigned rem;
    int s;
    // 4*1024 points per turn: the top 12 phase bits
    idx = ph[31:20];
    rem = idx[9:0];
    s = idx[10] ? int'(quarter_wave(SINE_N - rem)) : int'(quarter_wave(rem));
    return idx[11] ? -s : s;
  endfunction

  // Apply one command to the oscillator state, return the result it gives
  function automatic sld_pkg::res_t lfo_apply(input sld_pkg::cmd_t c);
    logic signed [sld_pkg::VAL_W-1:0] f;
    longint unsigned num;
    longint unsigned rt;
    longint unsigned quot;
    longint mag;
    int s;
    int a;
    int nxt;
    int diff;
    int cnt;
    logic neg;
    sld_pkg::res_t r;
    case (c.cmd)
      sld_pkg::CMD_TICK: begin
        if (running) begin
          // ramp one step toward the target, clamped
          nxt = int'(amp_cur) + int'(amp_step);
          if (amp_step > 0 && amp_tgt > amp_cur) begin
            amp_cur = (nxt > int'(amp_tgt)) ? amp_tgt : nxt[sld_pkg::VAL_W-1:0];
          end else if (amp_step < 0 && amp_tgt < amp_cur) begin
            amp_cur = (nxt < int'(amp_tgt)) ? amp_tgt : nxt[sld_pkg::VAL_W-1:0];
          end
          s = sine_q16(phase_acc);
          a = amp_cur;
          neg = (s < 0) != (a < 0);
          mag = (longint'(s < 0 ? -s : s) * longint'(a < 0 ? -a : a)) / 65536;
          out_q = sat_val(neg ? -mag : mag);
          phase_acc = phase_acc + phase_inc;
        end
      end
      sld_pkg::CMD_SET_AMP: begin
        diff = int'(c.target_amplitude) - int'(amp_cur);
        cnt = c.step_count;
        amp_tgt = c.target_amplitude;
        if (cnt == 0) begin
          amp_cur = c.target_amplitude;
          amp_step = sat_val(diff);
        end else begin
          amp_step = sat_val(diff / cnt);
        end
      end
      sld_pkg::CMD_SET_FREQ: begin
        f = c.frequency;
        phase_acc = '0;
        out_q = '0;
        running = (f > 0);
        if (running) begin
          // zero rate acts as one
          rt = (rate_q == '0) ? 64'd1 : {48'd0, rate_q};
          num = {40'd0, f} << 16;
          quot = num / rt;
          phase_inc = quot[31:0];
        end else begin
          phase_inc = '0;
        end
      end
      default: begin
        out_q = c.init_value;
        amp_cur = '0;
        amp_tgt = '0;
      end
    endcase
    r.lfo_value = out_q;
    r.amplitude = amp_cur;
    return r;
  endfunction

  task automatic add_row(input logic [1:0] op, input logic [sld_pkg::VAL_W-1:0] v,
                         input logic [sld_pkg::DEN_W-1:0] cnt, input logic chk,
                         input logic [sld_pkg::VAL_W-1:0] lfo,
                         input logic [sld_pkg::VAL_W-1:0] amp);
    dir_row_t row;
    row.item = '0;
    row.item.cmd = op;
    case (op)
      sld_pkg::CMD_SET_AMP: begin
        row.item.target_amplitude = v;
        row.item.step_count = cnt;
      end
      sld_pkg::CMD_SET_FREQ: row.item.frequency = v;
      sld_pkg::CMD_INIT:     row.item.init_value = v;
      default: ;
    endcase
    row.chk = chk;
    row.want.lfo_value = lfo;
    row.want.amplitude = amp;
    dir_q.push_back(row);
  endtask

  // Offer one command, wait for its transfer, queue the expected result
  task automatic drive_item(input sld_pkg::cmd_t c, input logic chk,
                            input sld_pkg::res_t want);
    sld_pkg::res_t pred;
    while (idle_en && $urandom_range(99) < 34) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= c;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    if (c.cmd == sld_pkg::CMD_TICK && running) run_ticks++;
    pred = lfo_apply(c);
    pending_res_q.push_back(chk ? want : pred);
    cmd_xfers++;
  endtask

  // Rate write, only with nothing in flight
  task automatic set_rate(input logic [sld_pkg::DEN_W-1:0] rate);
    cmd_if.valid <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= rate;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rate_q = rate;
    repeat (2) @(posedge clk_i);
  endtask

  function automatic sld_pkg::cmd_t rand_item();
    sld_pkg::cmd_t c;
    int unsigned pick;
    c.target_amplitude = 24'($urandom);
    c.step_count       = 16'($urandom);
    c.frequency        = 24'($urandom);
    c.init_value       = 24'($urandom);
    pick = $urandom_range(99);
    if (pick < 58) c.cmd = sld_pkg::CMD_TICK;
    else if (pick < 73) c.cmd = sld_pkg::CMD_SET_AMP;
    else if (pick < 86) c.cmd = sld_pkg::CMD_SET_FREQ;
    else c.cmd = sld_pkg::CMD_INIT;
    // mostly well-formed: running oscillator, short ramps
    if (c.cmd == sld_pkg::CMD_SET_AMP) begin
      if ($urandom_range(99) < 30) begin
        c.target_amplitude = 24'(int'($urandom_range(0, 24'h40000)) - 24'h20000);
      end
      if ($urandom_range(99) < 50) c.step_count = 16'($urandom_range(0, 16));
    end else if (c.cmd == sld_pkg::CMD_SET_FREQ) begin
      pick = $urandom_range(99);
      if (pick < 70) c.frequency = 24'($urandom_range(1, 24'h7FFFFF));
      else if (pick >= 92) c.frequency = '0;
    end
    return c;
  endfunction

  // Result sink with random stalls and one long hold-off
  initial begin : res_sink
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && cmd_xfers >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= !(idle_en && $urandom_range(99) < 34);
      end
    end
  end

  // Result check against the oldest pending expectation, plus watchdog
  always @(posedge clk_i) begin : res_check
    sld_pkg::res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (pending_res_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: lfo %h amp %h",
                   res_if.data.lfo_value, res_if.data.amplitude);
        end
      end else begin
        want = pending_res_q.pop_front();
        if (res_if.data.lfo_value !== want.lfo_value ||
            res_if.data.amplitude !== want.amplitude) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch at result %0d: lfo exp %h got %h, amp exp %h got %h",
                     results_seen, want.lfo_value, res_if.data.lfo_value,
                     want.amplitude, res_if.data.amplitude);
          end
        end
      end
    end
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_MAX) begin
      $display("timeout: no transfer for %0d cycles", STUCK_MAX);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin : stim
    sld_pkg::cmd_t c;
    sld_pkg::res_t none;
    int n;
    logic [sld_pkg::DEN_W-1:0] rate;
    logic [sld_pkg::DEN_W-1:0] rand_rate;

    errors = 0;
    results_seen = 0;
    cmd_xfers = 0;
    run_ticks = 0;
    stuck_cycles = 0;
    idle_en = 1'b1;
    none = '0;
    rand_rate = 16'($urandom_range(2, 65534));

    rate_q    = sld_pkg::RATE_RESET;
    out_q     = '0;
    amp_cur   = '0;
    amp_tgt   = '0;
    amp_step  = '0;
    phase_acc = '0;
    phase_inc = '0;
    running   = 1'b0;

    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_data_i   <= '0;
    cmd_if.valid <= 1'b0;
    cmd_if.data  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset state, value extremes, stopped oscillator,
    // quarter-turn steps at 15 Hz / 60 Hz rate to hit sine peaks and
    // output saturation, ramps up and down, step saturation
    add_row(sld_pkg::CMD_TICK, '0, '0, 1'b1, '0, '0);
    add_row(sld_pkg::CMD_INIT, sld_pkg::VAL_MAX, '0, 1'b1, sld_pkg::VAL_MAX, '0);
    add_row(sld_pkg::CMD_INIT, sld_pkg::VAL_MIN, '0, 1'b1, sld_pkg::VAL_MIN, '0);
    add_row(sld_pkg::CMD_SET_AMP, sld_pkg::VAL_MAX, '0, 1'b1,
            sld_pkg::VAL_MIN, sld_pkg::VAL_MAX);
    add_row(sld_pkg::CMD_SET_FREQ, '0, '0, 1'b1, '0, sld_pkg::VAL_MAX);
    add_row(sld_pkg::CMD_TICK, '0, '0, 1'b1, '0, sld_pkg::VAL_MAX);
    add_row(sld_pkg::CMD_SET_FREQ, sld_pkg::VAL_MIN, '0, 1'b1, '0, sld_pkg::VAL_MAX);
    add_row(sld_pkg::CMD_SET_FREQ, 24'h0F0000, '0, 1'b1, '0, sld_pkg::VAL_MAX);
    add_row(sld_pkg::CMD_TICK, '0, '0, 1'b1, '0, sld_pkg::VAL_MAX);
    add_row(sld_pkg::CMD_TICK, '0, '0, 1'b1, sld_pkg::VAL_MAX, sld_pkg::VAL_MAX);
    add_row(sld_pkg::CMD_SET_AMP, sld_pkg::VAL_MIN, '0, 1'b1,
            sld_pkg::VAL_MAX, sld_pkg::VAL_MIN);
    add_row(sld_pkg::CMD_TICK, '0, '0, 1'b1, '0, sld_pkg::VAL_MIN);
    add_row(sld_pkg::CMD_TICK, '0, '0, 1'b1, sld_pkg::VAL_MAX, sld_pkg::VAL_MIN);
    add_row(sld_pkg::CMD_SET_AMP, sld_pkg::VAL_MAX, 16'hFFFF, 1'b0, '0, '0);
    add_row(sld_pkg::CMD_TICK, '0, '0, 1'b0, '0, '0);
    add_row(sld_pkg::CMD_TICK, '0, '0, 1'b0, '0, '0);
    add_row(sld_pkg::CMD_SET_AMP, sld_pkg::VAL_MIN, 16'd1, 1'b0, '0, '0);
    add_row(sld_pkg::CMD_TICK, '0, '0, 1'b0, '0, '0);
    add_row(sld_pkg::CMD_SET_AMP, 24'h010000, 16'd3, 1'b0, '0, '0);
    add_row(sld_pkg::CMD_TICK, '0, '0, 1'b0, '0, '0);
    add_row(sld_pkg::CMD_TICK, '0, '0, 1'b0, '0, '0);
    add_row(sld_pkg::CMD_TICK, '0, '0, 1'b0, '0, '0);
    add_row(sld_pkg::CMD_SET_FREQ, sld_pkg::VAL_MAX, '0, 1'b0, '0, '0);
    add_row(sld_pkg::CMD_TICK, '0, '0, 1'b0, '0, '0);
    add_row(sld_pkg::CMD_INIT, 24'h123456, '0, 1'b1, 24'h123456, '0);
    add_row(sld_pkg::CMD_TICK, '0, '0, 1'b0, '0, '0);
    foreach (dir_q[i]) drive_item(dir_q[i].item, dir_q[i].chk, dir_q[i].want);

    // Random: one block of items per rate setting, one block without idling
    for (int p = 0; p < PHASE_SETS; p++) begin
      case (p)
        0: rate = 16'd1;
        1: rate = 16'hFFFF;
        2: rate = 16'd0;
        3: rate = 16'd44100;
        4: rate = rand_rate;
        default: rate = sld_pkg::RATE_RESET;
      endcase
      set_rate(rate);
      idle_en = (p != 3);
      n = 0;
      while (n < PER_SET) begin
        c = rand_item();
        if (c.cmd != sld_pkg::CMD_TICK || running) n++;
        drive_item(c, 1'b0, none);
      end
    end
    idle_en = 1'b1;
    cmd_if.valid <= 1'b0;

    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("run: %0d commands, %0d ticks on a running oscillator, %0d results checked",
             cmd_xfers, run_ticks, results_seen);
    $display("rates 60, 1, 65535, 0, 44100, %0d, 60; one %0d-cycle sink hold-off",
             rand_rate, HOLD_LEN);
    if (errors == 0 && pending_res_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
